// ----- hdl/a2b_pkg.sv -----
// ---------------------------------------------------------------------------
// a2b_pkg: ASCII to Baudot shift encoder package
// Word types, teleprinter codes, register indexes and the character table.
// ---------------------------------------------------------------------------
package a2b_pkg;

   localparam int unsigned CODE_WIDTH      = 5;
   localparam int unsigned COUNT_WIDTH     = 7;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 7;
   localparam int unsigned LIST_DEPTH      = 4;

   localparam logic [1:0] KIND_CHAR  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_ENABLE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINE_LIMIT   = 1'b1;

   localparam logic [CODE_WIDTH-1:0] CODE_LTRS  = 5'd0;
   localparam logic [CODE_WIDTH-1:0] CODE_FIGS  = 5'd4;
   localparam logic [CODE_WIDTH-1:0] CODE_LF    = 5'd23;
   localparam logic [CODE_WIDTH-1:0] CODE_CR    = 5'd29;
   localparam logic [CODE_WIDTH-1:0] CODE_SPACE = 5'd27;

   localparam logic [7:0] BYTE_LF      = 8'd10;
   localparam logic [7:0] BYTE_CR      = 8'd13;
   localparam logic [7:0] BYTE_SPACE   = 8'd32;
   localparam logic [7:0] BYTE_UPPER_A = 8'd65;
   localparam logic [7:0] BYTE_UPPER_Z = 8'd90;
   localparam logic [7:0] BYTE_LOWER_A = 8'd97;
   localparam logic [7:0] BYTE_LOWER_Z = 8'd122;
   localparam logic [7:0] CASE_OFFSET  = 8'd32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX        = 7'd127;
   localparam logic [COUNT_WIDTH-1:0] LINE_LIMIT_RESET = 7'd69;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] ascii_char;
   } req_type;

   typedef struct packed {
      logic [CODE_WIDTH-1:0] baudot_code;
      logic                  last;
   } rsp_type;

   function automatic logic [CODE_WIDTH-1:0] lookup_code(input logic [7:0] c);
      logic [CODE_WIDTH-1:0] code;
      case (c)
         8'd65, 8'd45:  code = 5'd7;
         8'd66, 8'd63:  code = 5'd12;
         8'd67, 8'd58:  code = 5'd17;
         8'd68, 8'd5:   code = 5'd13;
         8'd69, 8'd51:  code = 5'd15;
         8'd70:         code = 5'd9;
         8'd71:         code = 5'd20;
         8'd72:         code = 5'd26;
         8'd73, 8'd56:  code = 5'd19;
         8'd74, 8'd7:   code = 5'd5;
         8'd75, 8'd40:  code = 5'd1;
         8'd76, 8'd41:  code = 5'd22;
         8'd77, 8'd46:  code = 5'd24;
         8'd78, 8'd44:  code = 5'd25;
         8'd79, 8'd57:  code = 5'd28;
         8'd80, 8'd48:  code = 5'd18;
         8'd81, 8'd49:  code = 5'd2;
         8'd82, 8'd52:  code = 5'd21;
         8'd83, 8'd39:  code = 5'd11;
         8'd84, 8'd53:  code = 5'd30;
         8'd85, 8'd55:  code = 5'd3;
         8'd86, 8'd61:  code = 5'd16;
         8'd87, 8'd50:  code = 5'd6;
         8'd88, 8'd47:  code = 5'd8;
         8'd89, 8'd54:  code = 5'd10;
         8'd90, 8'd43:  code = 5'd14;
         BYTE_CR:       code = CODE_CR;
         BYTE_LF:       code = CODE_LF;
         8'd19:         code = CODE_FIGS;
         BYTE_SPACE:    code = CODE_SPACE;
         default:       code = CODE_LTRS;
      endcase
      return code;
   endfunction

endpackage

// ----- hdl/ascii_to_baudot_shift_encoder.sv -----
// ---------------------------------------------------------------------------
// ascii_to_baudot_shift_encoder: ASCII to Baudot shift encoder
// Encodes ASCII bytes into 5-bit teleprinter codes with shift insertion,
// message framing and an automatic line break after a set line length.
// ---------------------------------------------------------------------------
//  channel  | ports                      | direction | payload
//  request  | req_valid req_stall req_data | in      | kind, ascii_char
//  response | rsp_valid rsp_stall rsp_data | out     | baudot_code, last
//  csr      | csr_we csr_index csr_wdata   | in      | frame_enable, line_limit
//
//  An item is encoded in the cycle it is taken into a 4-entry code list.
//  The list drains one code per cycle into the response register while the
//  response is not stalled; an item that causes no code leaves it empty.
//  A new item is taken in the cycle the last code of the list moves out.
//  Reset clears shift to letters, the column count and the list, and loads
//  frame_enable 1 and line_limit 69. Response stall holds the response word.
// ---------------------------------------------------------------------------
module ascii_to_baudot_shift_encoder (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  a2b_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output a2b_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_we,
   input  logic [a2b_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [a2b_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   import a2b_pkg::*;

   logic                   frame_enable_ff, frame_enable_in;
   logic [COUNT_WIDTH-1:0] line_limit_ff, line_limit_in;
   logic                   letters_ff, letters_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [2:0]             rem_ff, rem_in;
   logic [CODE_WIDTH-1:0]  list_ff [LIST_DEPTH];
   logic [CODE_WIDTH-1:0]  list_in [LIST_DEPTH];
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   out_free;
   logic                   pop;
   logic                   req_accept;

   logic [CODE_WIDTH-1:0]  enc_list [LIST_DEPTH];
   logic [2:0]             enc_n;
   logic                   enc_letters;
   logic [COUNT_WIDTH-1:0] enc_count;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign pop        = out_free && (rem_ff != 3'd0);
   assign req_stall  = (rem_ff > 3'd1) || ((rem_ff == 3'd1) && !out_free);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      logic [7:0]             c_up;
      logic [CODE_WIDTH-1:0]  code;
      logic                   is_letter;
      logic                   mapped;
      logic [COUNT_WIDTH-1:0] count_mid;
      logic                   fire;
      logic [CODE_WIDTH-1:0]  pre0, pre1;
      logic [1:0]             pre_n;

      c_up      = req_data.ascii_char;
      code      = CODE_LTRS;
      is_letter = 1'b0;
      mapped    = 1'b0;
      count_mid = count_ff;
      fire      = 1'b0;
      pre0      = CODE_LTRS;
      pre1      = CODE_LTRS;
      pre_n     = 2'd0;

      enc_letters = letters_ff;
      enc_count   = count_ff;
      enc_n       = 3'd0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         enc_list[i] = CODE_LTRS;
      end

      case (req_data.kind)
         KIND_START, KIND_END: begin
            enc_letters = 1'b1;
            enc_count   = '0;
            enc_list[0] = CODE_LTRS;
            enc_list[1] = CODE_LF;
            enc_list[2] = CODE_CR;
            enc_n       = frame_enable_ff ? 3'd3 : 3'd0;
         end
         KIND_CHAR: begin
            if (req_data.ascii_char >= BYTE_LOWER_A && req_data.ascii_char <= BYTE_LOWER_Z) begin
               c_up = req_data.ascii_char - CASE_OFFSET;
            end
            code      = lookup_code(c_up);
            mapped    = (code != CODE_LTRS);
            is_letter = (c_up >= BYTE_UPPER_A) && (c_up <= BYTE_UPPER_Z);
            if (mapped) begin
               if (count_ff != COUNT_MAX) begin
                  count_mid = count_ff + 7'd1;
               end
               if (is_letter) begin
                  enc_letters = 1'b1;
                  if (!letters_ff) begin
                     pre0  = CODE_LTRS;
                     pre1  = code;
                     pre_n = 2'd2;
                  end else begin
                     pre0  = code;
                     pre_n = 2'd1;
                  end
               end else if (!letters_ff || c_up == BYTE_CR || c_up == BYTE_LF ||
                            c_up == BYTE_SPACE) begin
                  pre0  = code;
                  pre_n = 2'd1;
               end else begin
                  enc_letters = 1'b0;
                  pre0  = CODE_FIGS;
                  pre1  = code;
                  pre_n = 2'd2;
               end
            end
            if (c_up == BYTE_LF) begin
               count_mid = '0;
            end
            fire      = (line_limit_ff != '0) && (count_mid >= line_limit_ff);
            enc_count = fire ? '0 : count_mid;
            case (pre_n)
               2'd1: begin
                  enc_list[0] = pre0;
                  enc_list[1] = CODE_LF;
                  enc_list[2] = CODE_CR;
               end
               2'd2: begin
                  enc_list[0] = pre0;
                  enc_list[1] = pre1;
                  enc_list[2] = CODE_LF;
                  enc_list[3] = CODE_CR;
               end
               default: begin
                  enc_list[0] = CODE_LF;
                  enc_list[1] = CODE_CR;
               end
            endcase
            enc_n = {1'b0, pre_n} + (fire ? 3'd2 : 3'd0);
         end
         default: begin
            enc_n = 3'd0;
         end
      endcase
   end

   always_comb begin
      frame_enable_in = frame_enable_ff;
      line_limit_in   = line_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_ENABLE: frame_enable_in = csr_wdata[0];
            CSR_LINE_LIMIT:   line_limit_in   = csr_wdata[COUNT_WIDTH-1:0];
            default: begin
               frame_enable_in = frame_enable_ff;
            end
         endcase
      end

      letters_in = req_accept ? enc_letters : letters_ff;
      count_in   = req_accept ? enc_count : count_ff;

      rem_in = rem_ff;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         list_in[i] = list_ff[i];
      end
      if (req_accept) begin
         rem_in = enc_n;
         for (int i = 0; i < LIST_DEPTH; i++) begin
            list_in[i] = enc_list[i];
         end
      end else if (pop) begin
         rem_in = rem_ff - 3'd1;
         for (int i = 0; i < LIST_DEPTH - 1; i++) begin
            list_in[i] = list_ff[i+1];
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in       = pop;
         rsp_in.baudot_code = list_ff[0];
         rsp_in.last        = (rem_ff == 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_enable_ff <= 1'b1;
         line_limit_ff   <= LINE_LIMIT_RESET;
         letters_ff      <= 1'b1;
         count_ff        <= '0;
         rem_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_enable_ff <= frame_enable_in;
         line_limit_ff   <= line_limit_in;
         letters_ff      <= letters_in;
         count_ff        <= count_in;
         rem_ff          <= rem_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
         list_ff[i] <= list_in[i];
      end
      rsp_ff <= rsp_in;
   end

   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 3'd4)
      else $error("code list count out of range");

   a_accept_empty : assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (rem_ff == 3'd0) || ((rem_ff == 3'd1) && out_free))
      else $error("word taken while code list still busy");

   a_last_pop : assert property (@(posedge clock) disable iff (reset)
      (out_free && rem_ff == 3'd1) |=> rsp_valid_ff && rsp_ff.last)
      else $error("final code not marked last");

   a_frame_letters : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.kind == KIND_START || req_data.kind == KIND_END))
      |=> letters_ff && (count_ff == '0))
      else $error("framing word did not restore letters shift");

endmodule

// ----- verif/a2b_tracker_pkg.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// a2b_tracker_pkg: code stream tracker for the ASCII to Baudot encoder bench
// Keeps its own copy of shift mode, column count and registers, works out
// the Baudot words each accepted input word causes and matches them against
// the words that leave the block, in order.
// ---------------------------------------------------------------------------
package a2b_tracker_pkg;
   import a2b_pkg::*;

   class baudot_tracker;
      bit                     frame_on;
      logic [COUNT_WIDTH-1:0] wrap_at;
      bit                     in_letters;
      logic [COUNT_WIDTH-1:0] line_col;
      rsp_type                owed_codes[$];
      logic [CODE_WIDTH-1:0]  fresh_codes[$];
      int                     fail_count;
      int                     words_checked;

      function new();
         frame_on      = 1'b1;
         wrap_at       = LINE_LIMIT_RESET;
         in_letters    = 1'b1;
         line_col      = '0;
         fail_count    = 0;
         words_checked = 0;
      endfunction

      function void report(string msg);
         if (fail_count < 40) $display("mismatch: %s", msg);
         fail_count++;
      endfunction

      function void set_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
         if (idx == CSR_FRAME_ENABLE) frame_on = val[0];
         else if (idx == CSR_LINE_LIMIT) wrap_at = val[COUNT_WIDTH-1:0];
      endfunction

      function logic [CODE_WIDTH-1:0] table_code(logic [7:0] c);
         logic [CODE_WIDTH-1:0] code;
         case (c)
            "A", "-":        code = 5'd7;
            "B", "?":        code = 5'd12;
            "C", ":":        code = 5'd17;
            "D", 8'd5:       code = 5'd13;
            "E", "3":        code = 5'd15;
            "F":             code = 5'd9;
            "G":             code = 5'd20;
            "H":             code = 5'd26;
            "I", "8":        code = 5'd19;
            "J", 8'd7:       code = 5'd5;
            "K", "(":        code = 5'd1;
            "L", ")":        code = 5'd22;
            "M", ".":        code = 5'd24;
            "N", ",":        code = 5'd25;
            "O", "9":        code = 5'd28;
            "P", "0":        code = 5'd18;
            "Q", "1":        code = 5'd2;
            "R", "4":        code = 5'd21;
            "S", 8'd39:      code = 5'd11;
            "T", "5":        code = 5'd30;
            "U", "7":        code = 5'd3;
            "V", "=":        code = 5'd16;
            "W", "2":        code = 5'd6;
            "X", "/":        code = 5'd8;
            "Y", "6":        code = 5'd10;
            "Z", "+":        code = 5'd14;
            BYTE_CR:         code = CODE_CR;
            BYTE_LF:         code = CODE_LF;
            8'd19:           code = CODE_FIGS;
            BYTE_SPACE:      code = CODE_SPACE;
            default:         code = CODE_LTRS;
         endcase
         return code;
      endfunction

      function void emit(logic [CODE_WIDTH-1:0] code);
         if (fresh_codes.size() < LIST_DEPTH) fresh_codes.push_back(code);
      endfunction

      // Encode one accepted input word into the words it owes.
      function void take_word(req_type w);
         logic [7:0]            c;
         logic [CODE_WIDTH-1:0] code;
         rsp_type               r;
         fresh_codes.delete();
         c = w.ascii_char;
         if (w.kind == KIND_START || w.kind == KIND_END) begin
            in_letters = 1'b1;
            line_col   = '0;
            if (frame_on) begin
               emit(CODE_LTRS);
               emit(CODE_LF);
               emit(CODE_CR);
            end
         end else if (w.kind == KIND_CHAR) begin
            if (c >= BYTE_LOWER_A && c <= BYTE_LOWER_Z) c = c - CASE_OFFSET;
            code = table_code(c);
            if (code != CODE_LTRS) begin
               if (line_col < COUNT_MAX) line_col++;
               if (c >= BYTE_UPPER_A && c <= BYTE_UPPER_Z) begin
                  if (!in_letters) emit(CODE_LTRS);
                  in_letters = 1'b1;
                  emit(code);
               end else if (!in_letters || c == BYTE_CR || c == BYTE_LF || c == BYTE_SPACE) begin
                  emit(code);
               end else begin
                  emit(CODE_FIGS);
                  emit(code);
                  in_letters = 1'b0;
               end
            end
            if (c == BYTE_LF) line_col = '0;
            if (wrap_at != 0 && line_col >= wrap_at) begin
               emit(CODE_LF);
               emit(CODE_CR);
               line_col = '0;
            end
         end
         foreach (fresh_codes[i]) begin
            r.baudot_code = fresh_codes[i];
            r.last        = (i == fresh_codes.size() - 1);
            owed_codes.push_back(r);
         end
      endfunction

      function void match_word(rsp_type got);
         rsp_type want;
         if (owed_codes.size() == 0) begin
            report($sformatf("unexpected word code %0d last %0b", got.baudot_code, got.last));
            return;
         end
         want = owed_codes.pop_front();
         if (got.baudot_code !== want.baudot_code)
            report($sformatf("word %0d code %0d, want %0d", words_checked, got.baudot_code,
                             want.baudot_code));
         if (got.last !== want.last)
            report($sformatf("word %0d last %0b, want %0b", words_checked, got.last, want.last));
         words_checked++;
      endfunction

      function void close_out();
         if (owed_codes.size() != 0)
            report($sformatf("%0d words never arrived", owed_codes.size()));
      endfunction
   endclass

endpackage

// ----- verif/tb_ascii_to_baudot_shift_encoder.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_ascii_to_baudot_shift_encoder: ASCII to Baudot shift encoder bench
// Drives directed and random ASCII messages through the encoder under
// several register settings and idle patterns, including a long response
// hold-off, and checks every Baudot word against a tracked expectation.
// ---------------------------------------------------------------------------
module tb_ascii_to_baudot_shift_encoder;
   import a2b_pkg::*;
   import a2b_tracker_pkg::*;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   localparam logic [1:0] KIND_UNUSED     = 2'd3;
   localparam logic [7:0] BYTE_SHIFT_LTRS = 8'd18;
   localparam logic [7:0] BYTE_SHIFT_FIGS = 8'd19;
   localparam logic [7:0] BYTE_APOSTROPHE = 8'd39;
   localparam int         CYCLE_LIMIT     = 400000;
   localparam string      FIG_TEXT        = "-?:3.8(),9014'57=2/6+";

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_we    = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   baudot_tracker tracker;
   int            words_sent     = 0;
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;
   int            hold_request   = 0;
   int            hold_left      = 0;
   int            cycle_count    = 0;

   ascii_to_baudot_shift_encoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   task automatic set_mode(input idle_mode_type m);
      case (m)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct  = 78;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 78;
         end
         default: begin
            send_idle_pct  = 21;
            recv_stall_pct = 21;
         end
      endcase
   endtask

   task automatic push_word(input logic [1:0] kind, input logic [7:0] ch);
      req_type w;
      w.kind       = kind;
      w.ascii_char = ch;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_word(w);
      words_sent++;
   endtask

   // Drop valid and wait until every owed word is out and the block is idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.owed_codes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input bit frame, input logic [COUNT_WIDTH-1:0] limit);
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_ENABLE;
      csr_wdata <= {{(CSR_DATA_WIDTH-1){1'b0}}, frame};
      @(posedge clock);
      csr_index <= CSR_LINE_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we    <= 1'b0;
      tracker.set_reg(CSR_FRAME_ENABLE, {{(CSR_DATA_WIDTH-1){1'b0}}, frame});
      tracker.set_reg(CSR_LINE_LIMIT, limit);
   endtask

   function automatic logic [7:0] pick_char(input bit no_breaks);
      int r;
      int idx;
      r   = $urandom_range(99);
      idx = $urandom_range(FIG_TEXT.len() + 2);
      if (r < 30) return BYTE_UPPER_A + 8'($urandom_range(25));
      if (r < 45) return BYTE_LOWER_A + 8'($urandom_range(25));
      if (r < 75) begin
         if (idx < FIG_TEXT.len()) return FIG_TEXT[idx];
         case (idx - FIG_TEXT.len())
            0:       return 8'd5;
            1:       return 8'd7;
            default: return BYTE_SHIFT_FIGS;
         endcase
      end
      if (r < 88) begin
         if (no_breaks) return BYTE_SPACE;
         case ($urandom_range(2))
            0:       return BYTE_CR;
            1:       return BYTE_LF;
            default: return BYTE_SPACE;
         endcase
      end
      if (no_breaks) return BYTE_UPPER_A + 8'($urandom_range(25));
      return 8'($urandom_range(255));
   endfunction

   task automatic send_message(input int len, input bit framed, input bit no_breaks);
      int i;
      if (framed) push_word(KIND_START, 8'($urandom_range(255)));
      for (i = 0; i < len; i++) begin
         if (!no_breaks && $urandom_range(99) < 3) push_word(KIND_UNUSED, 8'($urandom_range(255)));
         else push_word(KIND_CHAR, pick_char(no_breaks));
      end
      if (framed) push_word(KIND_END, 8'($urandom_range(255)));
   endtask

   task automatic random_phase(input bit frame, input logic [COUNT_WIDTH-1:0] limit,
                               input idle_mode_type m, input int target, input int hold);
      int first;
      settle();
      configure(frame, limit);
      set_mode(m);
      hold_request = hold;
      first = words_sent;
      while (words_sent - first < target) send_message($urandom_range(1, 12), 1'b1, 1'b0);
   endtask

   // Response side: check accepted words, then pick the next stall.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && !rsp_stall) tracker.match_word(rsp_data);
            if (hold_request > 0) begin
               hold_left    = hold_request;
               hold_request = 0;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= ($urandom_range(99) < recv_stall_pct);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_mode(IDLE_NONE);

      push_word(KIND_START, 8'd0);
      push_word(KIND_CHAR, "A");
      push_word(KIND_CHAR, "z");
      push_word(KIND_CHAR, "1");
      push_word(KIND_CHAR, BYTE_SPACE);
      push_word(KIND_CHAR, "B");
      push_word(KIND_CHAR, BYTE_SHIFT_FIGS);
      push_word(KIND_CHAR, "-");
      push_word(KIND_CHAR, BYTE_CR);
      push_word(KIND_CHAR, BYTE_LF);
      push_word(KIND_CHAR, BYTE_SHIFT_LTRS);
      push_word(KIND_CHAR, 8'd0);
      push_word(KIND_CHAR, 8'd255);
      push_word(KIND_UNUSED, "A");
      push_word(KIND_CHAR, "a");
      push_word(KIND_CHAR, BYTE_APOSTROPHE);
      push_word(KIND_END, 8'd255);
      settle();
      configure(1'b0, 7'd2);
      push_word(KIND_START, 8'd170);
      push_word(KIND_CHAR, "Q");
      push_word(KIND_CHAR, "W");
      push_word(KIND_CHAR, "9");
      push_word(KIND_CHAR, "0");
      push_word(KIND_CHAR, "E");
      push_word(KIND_CHAR, "8");
      push_word(KIND_END, 8'd85);

      random_phase(1'b1, 7'd69, IDLE_NONE, 25, 80);
      random_phase(1'b0, 7'd1, IDLE_SENDER, 20, 0);
      random_phase(1'b1, 7'd127, IDLE_RECEIVER, 20, 0);

      // Run a long line with the limiter off so the column count saturates.
      settle();
      configure(1'b0, 7'd0);
      set_mode(IDLE_BOTH);
      send_message(135, 1'b0, 1'b1);
      settle();
      configure(1'b1, 7'd100);
      set_mode(IDLE_SENDER);
      send_message(4, 1'b0, 1'b0);

      random_phase(1'b1, 7'd100, IDLE_SENDER, 12, 0);
      random_phase(1'b1, 7'd5, IDLE_RECEIVER, 12, 0);
      random_phase(1'b0, 7'd12, IDLE_NONE, 12, 0);
      random_phase(1'b1, 7'($urandom_range(1, 127)), IDLE_BOTH, 12, 0);

      settle();
      repeat (12) @(posedge clock);
      tracker.close_out();
      if (tracker.fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/a2b_pkg.sv
hdl/ascii_to_baudot_shift_encoder.sv
verif/a2b_tracker_pkg.sv
verif/tb_ascii_to_baudot_shift_encoder.sv
